// ----- hw/rtl/polyline_area_simplifier_defines.svh -----
// Assertion macros for the polyline area simplifier.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef POLYLINE_AREA_SIMPLIFIER_DEFINES_SVH
`define POLYLINE_AREA_SIMPLIFIER_DEFINES_SVH

// Check a property on every rising edge outside reset
`define PAS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition never holds outside reset
`define PAS_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/pas_pkg.sv -----
// Shared types and constants for the polyline area simplifier.
// No dependencies; imported by pas_alu, the top level and the testbench.
package pas_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_W        = 24;
    localparam int DIFF_W         = COORD_W + 1;
    localparam int PROD_W         = 2 * DIFF_W;
    localparam int ACC_W          = PROD_W + 2;
    localparam int AREA_W         = 50;
    localparam int TOL_W          = 16;
    localparam int MINP_W         = 7;
    localparam int CFG_W          = 16;
    localparam int CFG_AW         = 1;

    localparam logic [CFG_AW-1:0] CFG_TOLERANCE  = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_MIN_POINTS = 1'b1;

    localparam logic [TOL_W-1:0]  TOL_RESET  = 16'd256;
    localparam logic [MINP_W-1:0] MINP_RESET = 7'd3;
    localparam logic [MINP_W-1:0] MINP_FLOOR = 7'd2;

    // Closed-path test: squared first-to-last distance below 4 px^2 in Q.16
    localparam logic [ACC_W-1:0] CLOSE_DIST2 = ACC_W'(4 << 16);

    typedef enum logic [1:0] {
        ALU_NOP,
        ALU_LOAD,
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef enum logic [5:0] {
        S_IDLE, S_CHECK,
        S_THR_MUL, S_THR_LD, S_THR_SET,
        S_D_RA, S_D_RB, S_D_DB, S_D_M1, S_D_M2, S_D_ACC, S_D_CMP,
        S_INIT, S_INIT_NEXT,
        S_T_RA, S_T_RB, S_T_RC, S_T_DC, S_T_M1, S_T_M2, S_T_ACC, S_T_WR,
        S_LOOP, S_PK_RD, S_PK_CMP, S_PK_DONE,
        S_RF, S_RF_P, S_RF_Q, S_RF_CHK, S_RF_NEXT,
        S_EM_LAST, S_EM_SCAN, S_EM_RD, S_EM_WAIT, S_DONE
    } t_state;

endpackage

// ----- hw/rtl/pas_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/pas_alu.sv -----
// Shared multiply-accumulate unit: registered product, then accumulator.
// Depends on pas_pkg for widths and the operation codes.
module pas_alu
    import pas_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [DIFF_W-1:0] i_a,
    input  logic signed [DIFF_W-1:0] i_b,
    input  t_alu_op                  i_op,
    output logic signed [ACC_W-1:0]  o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  prod_ext;

    assign prod_ext = ACC_W'(r_prod);

    // Register the product of the current operands
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // Fold the previous product into the accumulator
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            ALU_LOAD: r_acc <= prod_ext;
            ALU_ADD:  r_acc <= r_acc + prod_ext;
            ALU_SUB:  r_acc <= r_acc - prod_ext;
            default:  r_acc <= r_acc;
        endcase
    end

    assign o_acc = r_acc;

endmodule

// ----- hw/rtl/polyline_area_simplifier.sv -----
// Top level of the polyline area simplifier: sequencer, point stores, gone flags.
// Depends on pas_pkg, pas_ram, pas_alu and polyline_area_simplifier_defines.svh.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  s_axis  | tvalid tready tdata{px,py} tlast=path_end | in
//  m_axis  | tvalid tready tdata{qx,qy} tlast tuser    | out
//  cfg     | i_cfg_we i_cfg_addr i_cfg_wdata           | in
//
// A point without the end mark is stored as it is taken, up to capacity. A path
// end runs the threshold and closure checks, the initial triangle areas, then per
// removal a scan of the weights and a refresh of up to four neighbor weights, and
// last the emission of the kept points; all of it runs through the one multiplier
// and the single read port of each store. Reset is synchronous, active low; it
// clears the sequencer, point count, overflow and gone flags and presets config.
// Input is not ready from the end mark until the last result transfer is done;
// a stalled result holds the sequencer in place.
`include "polyline_area_simplifier_defines.svh"

module polyline_area_simplifier
    import pas_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,  // px[23:0], py[47:24]
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [47:0]           m_axis_tdata,  // qx[23:0], qy[47:24]
    output logic                  m_axis_tlast,
    output logic [0:0]            m_axis_tuser,  // overflowed[0]
    input  logic                  i_cfg_we,
    input  logic [CFG_AW-1:0]     i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int VW = AW + 2;

    t_state r_state, n_state, r_ret;

    logic [TOL_W-1:0]  r_tol;
    logic [MINP_W-1:0] r_minp_cfg;
    logic [MINP_W-1:0] minp;

    logic [CW-1:0] r_cnt, r_rem, r_i, r_j;
    logic          r_ovf, r_closed, r_found;
    logic [MAX_POINTS-1:0] r_gone;
    logic [AW-1:0] r_ta, r_tb, r_tc, r_m, r_best, r_idx, r_p, r_q, r_last;
    logic [2:0]    r_k;
    logic [AREA_W-1:0] r_thr, r_bestv;

    logic signed [COORD_W-1:0] r_xa, r_ya;
    logic signed [DIFF_W-1:0]  r_dx1, r_dy1, r_dx2, r_dy2;
    logic [COORD_W-1:0] r_qx, r_qy;
    logic r_qlast, r_qovf;

    // Store ports and shared unit controls
    logic [AW-1:0]      crd_raddr, area_raddr;
    logic [47:0]        crd_rdata;
    logic               crd_we, area_we;
    logic [AREA_W-1:0]  area_rdata, area_wdata;
    logic signed [DIFF_W-1:0] alu_a, alu_b;
    t_alu_op            alu_op;
    logic signed [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]   acc_abs;

    logic s_xfer, m_xfer;
    logic [CW-1:0] nm1, hi;
    logic signed [COORD_W-1:0] rd_x, rd_y;
    logic signed [DIFF_W-1:0]  dxa, dya;
    logic [AW-1:0] p_dec, q_inc;
    logic [VW-1:0] v, w, n_v;
    logic          rf_ok;
    logic [AW-1:0] rf_idx;
    logic          init_go;

    assign s_xfer = s_axis_tvalid && s_axis_tready;
    assign m_xfer = m_axis_tvalid && m_axis_tready;
    assign minp   = (r_minp_cfg < MINP_FLOOR) ? MINP_FLOOR : r_minp_cfg;
    assign nm1    = r_cnt - CW'(1);
    assign hi     = r_closed ? nm1 : nm1 - CW'(1);
    assign rd_x   = crd_rdata[COORD_W-1:0];
    assign rd_y   = crd_rdata[2*COORD_W-1:COORD_W];
    assign dxa    = DIFF_W'(rd_x) - DIFF_W'(r_xa);
    assign dya    = DIFF_W'(rd_y) - DIFF_W'(r_ya);
    assign acc_abs = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    assign area_wdata = acc_abs[AREA_W-1:0];

    // Circular neighbor steps
    assign p_dec = (r_p == '0) ? nm1[AW-1:0] : r_p - AW'(1);
    assign q_inc = (CW'(r_q) == nm1) ? '0 : r_q + AW'(1);

    // Refresh index: removal position plus offset, wrapped or bounded
    assign v   = VW'(r_m) + VW'(r_k);
    assign n_v = VW'(r_cnt);
    always_comb begin
        w = v - VW'(2);
        if (r_closed) begin
            rf_ok = 1'b1;
            if (v < VW'(2)) begin
                w = v + n_v - VW'(2);
            end else if (w >= n_v) begin
                w = w - n_v;
            end
        end else begin
            rf_ok = (v >= VW'(3)) && (v <= n_v);
        end
        rf_idx = w[AW-1:0];
    end

    assign init_go = r_closed ? (r_i < r_cnt) : (r_i < nm1);

    // Point coordinate store
    pas_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_POINTS)) u_crd_ram (
        .i_clk   (i_clk),
        .i_we    (crd_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (crd_raddr),
        .o_rdata (crd_rdata)
    );

    // Doubled triangle area store
    pas_ram #(.WIDTH(AREA_W), .DEPTH(MAX_POINTS)) u_area_ram (
        .i_clk   (i_clk),
        .i_we    (area_we),
        .i_waddr (r_tb),
        .i_wdata (area_wdata),
        .i_raddr (area_raddr),
        .o_rdata (area_rdata)
    );

    pas_alu u_alu (
        .i_clk (i_clk),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_op  (alu_op),
        .o_acc (acc)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (s_xfer && s_axis_tlast) n_state = S_CHECK;
            S_CHECK: begin
                if (8'(r_cnt) <= 8'(minp)) n_state = S_EM_LAST;
                else                       n_state = S_THR_MUL;
            end
            S_THR_MUL:   n_state = S_THR_LD;
            S_THR_LD:    n_state = S_THR_SET;
            S_THR_SET:   n_state = S_D_RA;
            S_D_RA:      n_state = S_D_RB;
            S_D_RB:      n_state = S_D_DB;
            S_D_DB:      n_state = S_D_M1;
            S_D_M1:      n_state = S_D_M2;
            S_D_M2:      n_state = S_D_ACC;
            S_D_ACC:     n_state = S_D_CMP;
            S_D_CMP:     n_state = S_INIT;
            S_INIT:      n_state = init_go ? S_T_RA : S_LOOP;
            S_INIT_NEXT: n_state = S_INIT;
            S_T_RA:      n_state = S_T_RB;
            S_T_RB:      n_state = S_T_RC;
            S_T_RC:      n_state = S_T_DC;
            S_T_DC:      n_state = S_T_M1;
            S_T_M1:      n_state = S_T_M2;
            S_T_M2:      n_state = S_T_ACC;
            S_T_ACC:     n_state = S_T_WR;
            S_T_WR:      n_state = r_ret;
            S_LOOP: begin
                if (8'(r_rem) > 8'(minp)) n_state = S_PK_RD;
                else                      n_state = S_EM_LAST;
            end
            S_PK_RD:     n_state = S_PK_CMP;
            S_PK_CMP:    n_state = (r_j == hi) ? S_PK_DONE : S_PK_RD;
            S_PK_DONE:   n_state = r_found ? S_RF : S_EM_LAST;
            S_RF: begin
                if (!rf_ok || r_gone[rf_idx]) n_state = S_RF_NEXT;
                else                           n_state = S_RF_P;
            end
            S_RF_P:      if (!(r_gone[p_dec] && p_dec != r_idx)) n_state = S_RF_Q;
            S_RF_Q:      if (!(r_gone[q_inc] && q_inc != r_idx)) n_state = S_RF_CHK;
            S_RF_CHK: begin
                if (r_p != r_idx && r_q != r_idx && r_p != r_q) n_state = S_T_RA;
                else                                             n_state = S_RF_NEXT;
            end
            S_RF_NEXT:   n_state = (r_k == 3'd4) ? S_LOOP : S_RF;
            S_EM_LAST:   if (!r_gone[r_last]) n_state = S_EM_SCAN;
            S_EM_SCAN: begin
                if (r_j == r_cnt)                 n_state = S_DONE;
                else if (!r_gone[r_j[AW-1:0]])    n_state = S_EM_RD;
            end
            S_EM_RD:     n_state = S_EM_WAIT;
            S_EM_WAIT:   if (m_axis_tready) n_state = S_EM_SCAN;
            S_DONE:      n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Store addresses, shared unit operands and handshake outputs
    always_comb begin
        crd_raddr  = '0;
        area_raddr = r_j[AW-1:0];
        area_we    = 1'b0;
        alu_a      = r_dx1;
        alu_b      = r_dy2;
        alu_op     = ALU_NOP;
        unique case (r_state)
            S_THR_MUL: begin
                alu_a = $signed({{(DIFF_W - TOL_W){1'b0}}, r_tol});
                alu_b = $signed({{(DIFF_W - TOL_W){1'b0}}, r_tol});
            end
            S_THR_LD:  alu_op = ALU_LOAD;
            S_D_RB:    crd_raddr = nm1[AW-1:0];
            S_D_M1: begin
                alu_a = r_dx1;
                alu_b = r_dx1;
            end
            S_D_M2: begin
                alu_a  = r_dy1;
                alu_b  = r_dy1;
                alu_op = ALU_LOAD;
            end
            S_D_ACC:   alu_op = ALU_ADD;
            S_T_RA:    crd_raddr = r_ta;
            S_T_RB:    crd_raddr = r_tb;
            S_T_RC:    crd_raddr = r_tc;
            S_T_M2: begin
                alu_a  = r_dx2;
                alu_b  = r_dy1;
                alu_op = ALU_LOAD;
            end
            S_T_ACC:   alu_op = ALU_SUB;
            S_T_WR:    area_we = 1'b1;
            S_EM_SCAN: crd_raddr = r_j[AW-1:0];
            default: begin
                crd_raddr = '0;
            end
        endcase
    end

    assign crd_we        = s_xfer && (r_cnt < CW'(MAX_POINTS));
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_EM_WAIT);
    assign m_axis_tdata  = {r_qy, r_qx};
    assign m_axis_tlast  = r_qlast;
    assign m_axis_tuser  = r_qovf;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol      <= TOL_RESET;
            r_minp_cfg <= MINP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TOLERANCE:  r_tol      <= i_cfg_wdata[TOL_W-1:0];
                CFG_MIN_POINTS: r_minp_cfg <= i_cfg_wdata[MINP_W-1:0];
                default:        r_tol      <= r_tol;
            endcase
        end
    end

    // Sequencer state and control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_gone  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (s_xfer) begin
                        if (r_cnt < CW'(MAX_POINTS)) r_cnt <= r_cnt + CW'(1);
                        else                         r_ovf <= 1'b1;
                    end
                end
                S_PK_DONE: if (r_found) r_gone[r_best] <= 1'b1;
                S_DONE: begin
                    r_cnt  <= '0;
                    r_ovf  <= 1'b0;
                    r_gone <= '0;
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Working registers of the sequencer
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_CHECK:   r_last <= nm1[AW-1:0];
            S_THR_SET: r_thr  <= AREA_W'(acc[AREA_W-2:0]) << 1;
            S_D_RB: begin
                r_xa <= rd_x;
                r_ya <= rd_y;
            end
            S_D_DB: begin
                r_dx1 <= -dxa;
                r_dy1 <= -dya;
            end
            S_D_CMP: begin
                r_closed <= (r_cnt > CW'(3)) && ($unsigned(acc) < CLOSE_DIST2);
                r_i      <= ((r_cnt > CW'(3)) && ($unsigned(acc) < CLOSE_DIST2))
                            ? '0 : CW'(1);
                r_rem    <= r_cnt;
            end
            S_INIT: begin
                r_ta  <= (r_i == '0) ? nm1[AW-1:0] : AW'(r_i - CW'(1));
                r_tb  <= r_i[AW-1:0];
                r_tc  <= (r_i == nm1) ? '0 : AW'(r_i + CW'(1));
                r_ret <= S_INIT_NEXT;
            end
            S_INIT_NEXT: r_i <= r_i + CW'(1);
            S_T_RB: begin
                r_xa <= rd_x;
                r_ya <= rd_y;
            end
            S_T_RC: begin
                r_dx1 <= dxa;
                r_dy1 <= dya;
            end
            S_T_DC: begin
                r_dx2 <= dxa;
                r_dy2 <= dya;
            end
            S_LOOP: begin
                r_j     <= r_closed ? '0 : CW'(1);
                r_bestv <= r_thr;
                r_found <= 1'b0;
                r_last  <= nm1[AW-1:0];
            end
            S_PK_CMP: begin
                if (!r_gone[r_j[AW-1:0]] && area_rdata < r_bestv) begin
                    r_bestv <= area_rdata;
                    r_best  <= r_j[AW-1:0];
                    r_found <= 1'b1;
                end
                r_j <= r_j + CW'(1);
            end
            S_PK_DONE: begin
                r_m    <= r_best;
                r_k    <= '0;
                r_rem  <= r_rem - CW'(1);
                r_last <= nm1[AW-1:0];
            end
            S_RF: begin
                r_idx <= rf_idx;
                r_p   <= rf_idx;
                r_q   <= rf_idx;
            end
            S_RF_P: r_p <= p_dec;
            S_RF_Q: r_q <= q_inc;
            S_RF_CHK: begin
                r_ta  <= r_p;
                r_tb  <= r_idx;
                r_tc  <= r_q;
                r_ret <= S_RF_NEXT;
            end
            S_RF_NEXT: r_k <= r_k + 3'd1;
            S_EM_LAST: begin
                if (r_gone[r_last]) r_last <= r_last - AW'(1);
                r_j <= '0;
            end
            S_EM_SCAN: if (r_j != r_cnt && r_gone[r_j[AW-1:0]]) r_j <= r_j + CW'(1);
            S_EM_RD: begin
                r_qx    <= rd_x;
                r_qy    <= rd_y;
                r_qlast <= (r_j[AW-1:0] == r_last);
                r_qovf  <= r_ovf;
            end
            S_EM_WAIT: if (m_xfer) r_j <= r_j + CW'(1);
            default: r_k <= r_k;
        endcase
    end

    `PAS_NEVER(a_ready_excl, i_clk, i_rst_n, m_axis_tvalid && s_axis_tready, "input ready during result")
    `PAS_ASSERT(a_cnt_cap, i_clk, i_rst_n, r_cnt <= CW'(MAX_POINTS), "point count above capacity")
    `PAS_ASSERT(a_rem_floor, i_clk, i_rst_n, (r_state == S_LOOP) |-> (r_rem >= CW'(2)), "too few points left")
    `PAS_ASSERT(a_done_clear, i_clk, i_rst_n, (r_state == S_DONE) |=> (r_cnt == '0 && r_gone == '0 && !r_ovf), "path state not cleared")

endmodule

// ----- tb/polyline_area_simplifier_test.sv -----
// Self-checking testbench for the polyline area simplifier: streams paths in,
// predicts kept points in-line and compares every output transfer. Uses pas_pkg.
module polyline_area_simplifier_test
    import pas_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic        fin;
    } t_pt;

    typedef struct packed {
        logic [23:0] x;
        logic [23:0] y;
        logic        last;
        logic        ovf;
    } t_kept;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [47:0]       s_axis_tdata = '0;  // px[23:0], py[47:24]
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [47:0]       m_axis_tdata;       // qx[23:0], qy[47:24]
    logic              m_axis_tlast;
    logic [0:0]        m_axis_tuser;       // overflowed[0]
    logic              i_cfg_we = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr = CFG_TOLERANCE;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;

    polyline_area_simplifier u_top (.*);

    always #5 i_clk = ~i_clk;

    t_pt   pending_pts[$];
    t_kept kept_expect[$];
    int    fail_count = 0;
    int    send_idle_pct = 35;
    int    recv_idle_pct = 47;
    int    in_taken = 0;   // input transfers seen by the monitor
    int    in_seen = 0;    // input transfers already acted on by the driver

    // predictor state
    logic [15:0]        tol_reg = TOL_RESET;
    logic [6:0]         minp_reg = MINP_RESET;
    logic signed [23:0] path_x[64];
    logic signed [23:0] path_y[64];
    logic [63:0]        weight[64];
    bit                 removed[64];
    int                 path_len = 0;
    bit                 path_ovf = 0;

    function automatic logic [63:0] tri_area(int a, int b, int c);
        longint dx1, dy1, dx2, dy2, cr;
        dx1 = longint'(path_x[b]) - path_x[a];
        dy1 = longint'(path_y[b]) - path_y[a];
        dx2 = longint'(path_x[c]) - path_x[a];
        dy2 = longint'(path_y[c]) - path_y[a];
        cr = dx1 * dy2 - dx2 * dy1;
        return cr < 0 ? -cr : cr;
    endfunction

    function automatic int lightest(int lo, int hi, logic [63:0] thr);
        int best;
        logic [63:0] bv;
        best = -1;
        bv = thr;
        for (int i = lo; i <= hi; i++)
            if (!removed[i] && weight[i] < bv) begin
                bv = weight[i];
                best = i;
            end
        return best;
    endfunction

    // Simplify the loaded path and queue the kept points
    task automatic simplify_path();
        int n, minp, rem, m, idx, p, q, lastk;
        logic [63:0] thr, d2;
        longint dx, dy;
        n = path_len;
        minp = minp_reg < 2 ? 2 : int'(minp_reg);
        for (int i = 0; i < 64; i++) removed[i] = 0;
        if (n > minp) begin
            thr = 64'd2 * tol_reg * tol_reg;
            dx = longint'(path_x[0]) - path_x[n-1];
            dy = longint'(path_y[0]) - path_y[n-1];
            d2 = dx * dx + dy * dy;
            rem = n;
            if (n > 3 && d2 < (64'd4 << 16)) begin
                for (int i = 0; i < n; i++)
                    weight[i] = tri_area((i + n - 1) % n, i, (i + 1) % n);
                while (rem > minp) begin
                    m = lightest(0, n - 1, thr);
                    if (m < 0) break;
                    removed[m] = 1;
                    rem--;
                    for (int off = -2; off <= 2; off++) begin
                        idx = (m + off + n) % n;
                        if (removed[idx]) continue;
                        p = idx;
                        q = idx;
                        do p = (p + n - 1) % n; while (removed[p] && p != idx);
                        do q = (q + 1) % n; while (removed[q] && q != idx);
                        if (p != idx && q != idx && p != q)
                            weight[idx] = tri_area(p, idx, q);
                    end
                end
            end else begin
                for (int i = 1; i < n - 1; i++)
                    weight[i] = tri_area(i - 1, i, i + 1);
                while (rem > minp) begin
                    m = lightest(1, n - 2, thr);
                    if (m < 0) break;
                    removed[m] = 1;
                    rem--;
                    for (int off = -2; off <= 2; off++) begin
                        idx = m + off;
                        if (idx <= 0 || idx >= n - 1 || removed[idx]) continue;
                        p = idx - 1;
                        q = idx + 1;
                        while (p >= 0 && removed[p]) p--;
                        while (q < n && removed[q]) q++;
                        if (p >= 0 && q < n) weight[idx] = tri_area(p, idx, q);
                    end
                end
            end
        end
        lastk = -1;
        for (int i = 0; i < n; i++) if (!removed[i]) lastk = i;
        for (int i = 0; i < n; i++)
            if (!removed[i])
                kept_expect.insert(kept_expect.size(),
                                   '{path_x[i], path_y[i], i == lastk, path_ovf});
        path_len = 0;
        path_ovf = 0;
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    // Driver: present the next point, hold it until transferred; randomize result ready
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || in_seen != in_taken) begin
                in_seen = in_taken;
                if (pending_pts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {pending_pts[0].y, pending_pts[0].x};
                    s_axis_tlast  <= pending_pts[0].fin;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on input transfers, check output transfers
    always @(posedge i_clk) begin
        t_kept exp_k;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            void'(pending_pts.pop_front());
            in_taken++;
            if (path_len < 64) begin
                path_x[path_len] = s_axis_tdata[23:0];
                path_y[path_len] = s_axis_tdata[47:24];
                path_len++;
            end else begin
                path_ovf = 1;
            end
            if (s_axis_tlast) simplify_path();
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (kept_expect.size() == 0) begin
                report_mismatch("unexpected output point");
            end else begin
                exp_k = kept_expect.pop_front();
                if (m_axis_tdata[23:0] !== exp_k.x)
                    report_mismatch($sformatf("qx %h exp %h", m_axis_tdata[23:0], exp_k.x));
                if (m_axis_tdata[47:24] !== exp_k.y)
                    report_mismatch($sformatf("qy %h exp %h", m_axis_tdata[47:24], exp_k.y));
                if (m_axis_tlast !== exp_k.last)
                    report_mismatch($sformatf("last %b exp %b", m_axis_tlast, exp_k.last));
                if (m_axis_tuser[0] !== exp_k.ovf)
                    report_mismatch($sformatf("ovf %b exp %b", m_axis_tuser[0], exp_k.ovf));
            end
        end
    end

    task automatic write_reg(logic [CFG_AW-1:0] addr, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == CFG_TOLERANCE) tol_reg = val;
        else minp_reg = val[6:0];
    endtask

    task automatic wait_drained();
        while (pending_pts.size() > 0 || kept_expect.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic add_pt(int x, int y, bit fin);
        pending_pts.insert(pending_pts.size(), '{x[23:0], y[23:0], fin});
    endtask

    // Random path: mostly a jittered polygon or ring, sometimes noise
    task automatic add_path(int n);
        int cx, cy, r, j, style;
        cx = $urandom_range(8000) - 4000;
        cy = $urandom_range(8000) - 4000;
        r = 1 << $urandom_range(14, 4);
        j = 1 << $urandom_range(10, 0);
        style = $urandom_range(9);
        for (int i = 0; i < n; i++) begin
            if (style == 0)
                add_pt($urandom, $urandom, i == n - 1);
            else if (style < 4 && i == n - 1)
                add_pt(cx + r, cy + $urandom_range(2), 1);  // close the ring
            else
                add_pt(cx + ((i % 4 < 2) ? r : -r) + $urandom_range(j),
                       cy + i * (r / 4) + $urandom_range(j), i == n - 1);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: extremes, short, collinear, closed, overflow
        add_pt(-8388608, 8388607, 0); add_pt(8388607, -8388608, 0);
        add_pt(0, 0, 1);
        add_pt(5, 5, 1);
        add_pt(0, 0, 0); add_pt(256, 0, 0); add_pt(512, 0, 0); add_pt(768, 1, 1);
        add_pt(0, 0, 0); add_pt(256, 3, 0); add_pt(256, 256, 0);
        add_pt(1, 256, 0); add_pt(1, 1, 1);
        add_pt(-8388608, -8388608, 0); add_pt(8388607, 8388607, 0);
        add_pt(8388607, -8388608, 0); add_pt(-8388608, 8388607, 1);
        wait_drained();
        for (int i = 0; i < 66; i++) add_pt(i * 100, (i % 3) * 50, i == 65);
        wait_drained();
        write_reg(CFG_TOLERANCE, 16'hFFFF);
        write_reg(CFG_MIN_POINTS, 16'd0);
        add_path(8); add_path(5);
        wait_drained();
        write_reg(CFG_TOLERANCE, 16'd0);
        write_reg(CFG_MIN_POINTS, 16'd127);
        add_path(6);
        wait_drained();
        write_reg(CFG_MIN_POINTS, 16'd1);
        write_reg(CFG_TOLERANCE, 16'd4096);
        send_idle_pct = 35;
        recv_idle_pct = 47;
        for (int i = 0; i < 8; i++) add_path($urandom_range(12, 2));
        wait_drained();
        write_reg(CFG_MIN_POINTS, 16'd64);
        write_reg(CFG_TOLERANCE, 16'($urandom));
        send_idle_pct = 47;
        recv_idle_pct = 35;
        for (int i = 0; i < 10; i++) add_path($urandom_range(8, 1));
        wait_drained();
        write_reg(CFG_MIN_POINTS, 16'd2);
        write_reg(CFG_TOLERANCE, 16'd1024);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 4; i++) add_path($urandom_range(10, 2));
        wait_drained();
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule
